// ===== hdl/gpa_pkg.sv =====
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared types and constants for the softened gravity pair accumulator.
// ----------------------------------------------------------------------------
package gpa_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int E_W        = 64;
    localparam int DEN_W      = E_W + WORD_W;
    localparam int NUM_W      = 2 * WORD_W + 2 * FRAC_BITS;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int SQRT_STEPS = E_W / 2;
    localparam int SQ_STEPS   = 4;

    localparam logic [WORD_W-1:0] SOFTENING_RESET = 32'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] rx;
        logic signed [WORD_W-1:0] ry;
        logic signed [WORD_W-1:0] rz;
        logic [WORD_W-1:0]        mass;
        logic signed [WORD_W-1:0] acc_x;
        logic signed [WORD_W-1:0] acc_y;
        logic signed [WORD_W-1:0] acc_z;
        logic                     first;
        logic                     last;
        logic                     clipped;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] acc_x;
        logic signed [WORD_W-1:0] acc_y;
        logic signed [WORD_W-1:0] acc_z;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     clip;
    } diff_t;

    function automatic diff_t sat_diff(logic signed [WORD_W-1:0] a,
                                       logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] d;
        diff_t r;
        d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        r.clip  = (d[WORD_W] != d[WORD_W-1]);
        if (!r.clip)
            r.value = d[WORD_W-1:0];
        else if (d[WORD_W])
            r.value = {1'b1, {(WORD_W-1){1'b0}}};
        else
            r.value = {1'b0, {(WORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ===== hdl/gpa_front.sv =====
// ----------------------------------------------------------------------------
// gpa_front
// Accepts pair words, forms saturated separations and queues them.
// ----------------------------------------------------------------------------
module gpa_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    input  logic signed [31:0]  source_x,
    input  logic signed [31:0]  source_y,
    input  logic signed [31:0]  source_z,
    input  logic [31:0]         source_mass,
    input  logic signed [31:0]  start_acc_x,
    input  logic signed [31:0]  start_acc_y,
    input  logic signed [31:0]  start_acc_z,
    input  logic                first_pair,
    input  logic                last_pair,
    output logic                q_valid,
    output gpa_pkg::item_t      q_item,
    input  logic                q_pop
);

    gpa_pkg::item_t  mem_reg [2];
    logic            wr_reg, wr_next;
    logic            rd_reg, rd_next;
    logic [1:0]      cnt_reg, cnt_next;
    gpa_pkg::diff_t  dx, dy, dz;
    gpa_pkg::item_t  new_item;
    logic            do_push, do_pop;

    assign dx = gpa_pkg::sat_diff(source_x, target_x);
    assign dy = gpa_pkg::sat_diff(source_y, target_y);
    assign dz = gpa_pkg::sat_diff(source_z, target_z);

    always_comb
    begin
        new_item.rx      = dx.value;
        new_item.ry      = dy.value;
        new_item.rz      = dz.value;
        new_item.mass    = source_mass;
        new_item.acc_x   = start_acc_x;
        new_item.acc_y   = start_acc_y;
        new_item.acc_z   = start_acc_z;
        new_item.first   = first_pair;
        new_item.last    = last_pair;
        new_item.clipped = dx.clip | dy.clip | dz.clip;
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = do_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= new_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/gpa_back.sv =====
// ----------------------------------------------------------------------------
// gpa_back
// Evaluates the softened term per axis with shared iterative units and
// accumulates it with saturation.
// ----------------------------------------------------------------------------
module gpa_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         softening,
    input  logic                q_valid,
    input  gpa_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                res_push,
    output gpa_pkg::result_t    res_word,
    input  logic                res_full
);

    localparam int W  = gpa_pkg::WORD_W;
    localparam int EW = gpa_pkg::E_W;
    localparam int DW = gpa_pkg::DEN_W;
    localparam int NW = gpa_pkg::NUM_W;
    localparam int CW = gpa_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_DEN0, S_DEN1, S_DEN2, S_MUL, S_DIV, S_ACC, S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    gpa_pkg::item_t         it_reg, it_next;
    logic [EW-1:0]          e_reg, e_next;
    logic [EW-1:0]          prod_reg, prod_next;
    logic [EW-1:0]          x_reg, x_next;
    logic [EW-1:0]          res_reg, res_next;
    logic [EW-1:0]          pp_reg, pp_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [NW-1:0]          numer_reg, numer_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          quot_reg, quot_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [1:0]             ax_reg, ax_next;
    logic signed [W-1:0]    sx_reg, sx_next;
    logic signed [W-1:0]    sy_reg, sy_next;
    logic signed [W-1:0]    sz_reg, sz_next;
    logic                   ov_reg, ov_next;

    logic signed [W-1:0]    rsel, ssel;
    logic [W-1:0]           mag;
    logic [EW-1:0]          mprod;
    logic [EW-1:0]          bitv, trial;
    logic [5:0]             shamt;
    logic [DW:0]            rem_s;
    logic                   ge;
    logic                   neg, qover;
    logic [W-1:0]           qlim;
    logic signed [W:0]      term;
    logic signed [W+1:0]    acc;
    logic signed [W-1:0]    acc_sat;
    logic                   acc_clip;

    always_comb
    begin
        case (ax_reg)
            2'd0:    begin rsel = it_reg.rx; ssel = sx_reg; end
            2'd1:    begin rsel = it_reg.ry; ssel = sy_reg; end
            default: begin rsel = it_reg.rz; ssel = sz_reg; end
        endcase
    end

    assign mag   = rsel[W-1] ? W'(-rsel) : W'(rsel);
    assign mprod = mag * it_reg.mass;
    assign shamt = 6'd62 - {cnt_reg[4:0], 1'b0};
    assign bitv  = EW'(1) << shamt;
    assign trial = res_reg + bitv;
    assign rem_s = {rem_reg, numer_reg[NW-1]};
    assign ge    = (rem_s >= {1'b0, den_reg});

    always_comb
    begin
        neg   = rsel[W-1];
        qover = (|quot_reg[NW-1:W]) ||
                (neg ? (quot_reg[W-1:0] > {1'b1, {(W-1){1'b0}}}) : quot_reg[W-1]);
        if (qover)
            qlim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            qlim = quot_reg[W-1:0];
        term     = neg ? -$signed({1'b0, qlim}) : $signed({1'b0, qlim});
        acc      = {{2{ssel[W-1]}}, ssel} + {term[W], term};
        acc_clip = (acc[W+1:W-1] != {3{acc[W-1]}});
        if (!acc_clip)
            acc_sat = acc[W-1:0];
        else if (acc[W+1])
            acc_sat = {1'b1, {(W-1){1'b0}}};
        else
            acc_sat = {1'b0, {(W-1){1'b1}}};
    end

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        e_next     = e_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        pp_next    = pp_reg;
        den_next   = den_reg;
        numer_next = numer_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        ax_next    = ax_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sz_next    = sz_reg;
        ov_next    = ov_reg;
        q_pop      = 1'b0;
        res_push   = 1'b0;
        res_word.acc_x     = sx_reg;
        res_word.acc_y     = sy_reg;
        res_word.acc_z     = sz_reg;
        res_word.saturated = ov_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    it_next = q_item;
                    if (q_item.first)
                    begin
                        sx_next = q_item.acc_x;
                        sy_next = q_item.acc_y;
                        sz_next = q_item.acc_z;
                        ov_next = q_item.clipped;
                    end
                    else
                        ov_next = ov_reg | q_item.clipped;
                    e_next     = EW'(softening) << gpa_pkg::FRAC_BITS;
                    ax_next    = 2'd0;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (cnt_reg != CW'(0))
                    e_next = e_reg + prod_reg;
                prod_next = EW'($signed(rsel) * $signed(rsel));
                ax_next   = ax_reg + 2'd1;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(gpa_pkg::SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    x_next     = e_reg + prod_reg;
                    res_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                    res_next = res_reg >> 1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(gpa_pkg::SQRT_STEPS - 1))
                    state_next = S_DEN0;
            end
            S_DEN0:
            begin
                pp_next    = e_reg[W-1:0] * res_reg[W-1:0];
                state_next = S_DEN1;
            end
            S_DEN1:
            begin
                prod_next  = e_reg[EW-1:W] * res_reg[W-1:0];
                den_next   = DW'(pp_reg);
                state_next = S_DEN2;
            end
            S_DEN2:
            begin
                den_next   = den_reg + {prod_reg, {W{1'b0}}};
                ax_next    = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                numer_next = {mprod, {(NW-2*W){1'b0}}};
                rem_next   = '0;
                quot_next  = '0;
                cnt_next   = '0;
                state_next = (den_reg == '0) ? S_ACC : S_DIV;
            end
            S_DIV:
            begin
                rem_next   = ge ? DW'(rem_s - {1'b0, den_reg}) : rem_s[DW-1:0];
                quot_next  = {quot_reg[NW-2:0], ge};
                numer_next = numer_reg << 1;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                case (ax_reg)
                    2'd0:    sx_next = acc_sat;
                    2'd1:    sy_next = acc_sat;
                    default: sz_next = acc_sat;
                endcase
                ov_next = ov_reg | qover | acc_clip;
                if (ax_reg == 2'd2)
                    state_next = it_reg.last ? S_EMIT : S_IDLE;
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        it_reg    <= it_next;
        e_reg     <= e_next;
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        res_reg   <= res_next;
        pp_reg    <= pp_next;
        den_reg   <= den_next;
        numer_reg <= numer_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        ax_reg    <= ax_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sz_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sz_reg    <= sz_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== hdl/gpa_outq.sv =====
// ----------------------------------------------------------------------------
// gpa_outq
// Two-word result queue between the accumulator and the consumer.
// ----------------------------------------------------------------------------
module gpa_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_push,
    input  gpa_pkg::result_t    res_word,
    output logic                res_full,
    output logic                empty,
    input  logic                pop,
    output gpa_pkg::result_t    head
);

    gpa_pkg::result_t  mem_reg [2];
    logic              wr_reg, wr_next;
    logic              rd_reg, rd_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head     = mem_reg[rd_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = do_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= res_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/gravity_pair_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// gravity_pair_accumulate_core
// Softened pairwise gravity accumulator, Q16.16, with saturating sums.
// ----------------------------------------------------------------------------
// Each pair word passes through the evaluation unit in order: it is taken
// from the queue, the squared distance is formed, a bit-serial square root
// is taken, the denominator product is formed and, per axis, one multiply,
// a 96-step restoring division and one accumulate follow. A word with
// last_pair set then hands its result to the output queue, and a zero
// denominator skips the divisions. The divider sets the rate. Two pair words
// and two result words can wait in the input and output queues. A result
// appears only for a word with last_pair set.
// ----------------------------------------------------------------------------
module gravity_pair_accumulate_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    input  logic signed [31:0]  source_x,
    input  logic signed [31:0]  source_y,
    input  logic signed [31:0]  source_z,
    input  logic [31:0]         source_mass,
    input  logic signed [31:0]  start_acc_x,
    input  logic signed [31:0]  start_acc_y,
    input  logic signed [31:0]  start_acc_z,
    input  logic                first_pair,
    input  logic                last_pair,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  total_acc_x,
    output logic signed [31:0]  total_acc_y,
    output logic signed [31:0]  total_acc_z,
    output logic                saturated
);

    logic [31:0]        soft_reg;
    logic               q_valid, q_pop;
    gpa_pkg::item_t     q_item;
    logic               res_push, res_full;
    gpa_pkg::result_t   res_word, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            soft_reg <= gpa_pkg::SOFTENING_RESET;
        else if (cfg_we)
            soft_reg <= cfg_wdata;
    end

    gpa_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .target_x    (target_x),
        .target_y    (target_y),
        .target_z    (target_z),
        .source_x    (source_x),
        .source_y    (source_y),
        .source_z    (source_z),
        .source_mass (source_mass),
        .start_acc_x (start_acc_x),
        .start_acc_y (start_acc_y),
        .start_acc_z (start_acc_z),
        .first_pair  (first_pair),
        .last_pair   (last_pair),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    gpa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .softening (soft_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_full  (res_full)
    );

    gpa_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_word (res_word),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign total_acc_x = head.acc_x;
    assign total_acc_y = head.acc_y;
    assign total_acc_z = head.acc_z;
    assign saturated   = head.saturated;

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (soft_reg == $past(cfg_wdata)))
        else $error("softening register missed a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop |-> q_valid))
        else $error("pair popped from an empty queue");

endmodule

// ===== verif/tb_gravity_pair_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// tb_gravity_pair_accumulate_core
// Self-checking bench for the softened gravity pair accumulator. Pair words
// are queued by a stimulus process and fed to the block by a clocked driver;
// a bit-exact fixed-point predictor computes the expected acceleration sums,
// and a clocked monitor compares each popped result word against them. Runs
// several softening settings with random sender and receiver gaps.
// ----------------------------------------------------------------------------
module tb_gravity_pair_accumulate_core;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic [31:0]        mass;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic               first;
        logic               last;
    } pair_t;

    localparam int DRAIN_CYCLES = 800;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        push;
    logic        full;
    logic        empty;
    logic        pop;
    pair_t       drv;
    pair_t       cur;
    gpa_pkg::result_t got;

    pair_t       pending_pairs[$];
    gpa_pkg::result_t expected_totals[$];
    logic [31:0] eps2_model;
    logic signed [63:0] run_x, run_y, run_z;
    logic        run_clipped;
    int          send_idle;
    int          recv_idle;
    int          errors;

    gravity_pair_accumulate_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .target_x    (drv.tx),
        .target_y    (drv.ty),
        .target_z    (drv.tz),
        .source_x    (drv.sx),
        .source_y    (drv.sy),
        .source_z    (drv.sz),
        .source_mass (drv.mass),
        .start_acc_x (drv.ax),
        .start_acc_y (drv.ay),
        .start_acc_z (drv.az),
        .first_pair  (drv.first),
        .last_pair   (drv.last),
        .empty       (empty),
        .pop         (pop),
        .total_acc_x (got.acc_x),
        .total_acc_y (got.acc_y),
        .total_acc_z (got.acc_z),
        .saturated   (got.saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [63:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            run_clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            run_clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = res | (64'd1 << i);
            if (cand * cand <= x)
                res = cand;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] pull_term(logic signed [63:0] r,
                                                     logic [31:0] mass,
                                                     logic [127:0] den);
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] limit;
        logic signed [63:0] res;
        mag   = (r < 0) ? 64'(-r) : 64'(r);
        limit = (r < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (den == '0)
            return 64'sd0;
        num = {64'd0, mag * {32'd0, mass}};
        num = num << (2 * gpa_pkg::FRAC_BITS);
        q   = num / den;
        if (q > limit)
        begin
            run_clipped = 1'b1;
            q = limit;
        end
        res = $signed(q[63:0]);
        return (r < 0) ? -res : res;
    endfunction

    function automatic void accumulate_pair(pair_t p);
        logic signed [63:0] a, b, rx, ry, rz;
        logic [63:0]  e;
        logic [63:0]  root;
        logic [127:0] den;
        gpa_pkg::result_t t;
        if (p.first)
        begin
            run_x = p.ax;
            run_y = p.ay;
            run_z = p.az;
            run_clipped = 1'b0;
        end
        a = p.sx; b = p.tx; rx = clip32(a - b);
        a = p.sy; b = p.ty; ry = clip32(a - b);
        a = p.sz; b = p.tz; rz = clip32(a - b);
        e = 64'(rx * rx) + 64'(ry * ry) + 64'(rz * rz)
            + ({32'd0, eps2_model} << gpa_pkg::FRAC_BITS);
        root = floor_root(e);
        den  = {64'd0, e} * {64'd0, root};
        run_x = clip32(run_x + pull_term(rx, p.mass, den));
        run_y = clip32(run_y + pull_term(ry, p.mass, den));
        run_z = clip32(run_z + pull_term(rz, p.mass, den));
        if (p.last)
        begin
            t.acc_x = run_x[31:0];
            t.acc_y = run_y[31:0];
            t.acc_z = run_z[31:0];
            t.saturated = run_clipped;
            expected_totals.push_back(t);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            drv  <= '0;
        end
        else
        begin
            if (push && !full)
                accumulate_pair(cur);
            if (!push || !full)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    cur = pending_pairs.pop_front();
                    drv  <= cur;
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_totals.size() == 0)
                begin
                    $error("unexpected result word");
                    errors++;
                end
                else
                begin
                    gpa_pkg::result_t w;
                    w = expected_totals.pop_front();
                    if (got.acc_x !== w.acc_x)
                    begin
                        $error("total_acc_x exp %0d got %0d", w.acc_x, got.acc_x);
                        errors++;
                    end
                    if (got.acc_y !== w.acc_y)
                    begin
                        $error("total_acc_y exp %0d got %0d", w.acc_y, got.acc_y);
                        errors++;
                    end
                    if (got.acc_z !== w.acc_z)
                    begin
                        $error("total_acc_z exp %0d got %0d", w.acc_z, got.acc_z);
                        errors++;
                    end
                    if (got.saturated !== w.saturated)
                    begin
                        $error("saturated exp %0b got %0b", w.saturated, got.saturated);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic pair_t mk(logic signed [31:0] t, logic signed [31:0] s,
                                 logic [31:0] m, logic signed [31:0] acc,
                                 logic f, logic l);
        pair_t p;
        p.tx = t; p.ty = t; p.tz = t;
        p.sx = s; p.sy = s; p.sz = s;
        p.mass = m;
        p.ax = acc; p.ay = acc; p.az = acc;
        p.first = f;
        p.last  = l;
        return p;
    endfunction

    function automatic logic [31:0] near(logic [31:0] base);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            8, 9:    return base + $urandom_range(0, 512) - 256;
            default: return base + $urandom_range(0, 1 << 20) - (1 << 19);
        endcase
    endfunction

    function automatic void queue_run();
        pair_t p;
        int    len;
        logic [31:0] bx, by, bz;
        len = $urandom_range(1, 8);
        bx = $urandom; by = $urandom; bz = $urandom;
        if ($urandom_range(0, 3) != 0)
        begin
            bx = $urandom_range(0, 1 << 24) - (1 << 23);
            by = $urandom_range(0, 1 << 24) - (1 << 23);
            bz = $urandom_range(0, 1 << 24) - (1 << 23);
        end
        for (int i = 0; i < len; i++)
        begin
            p.tx = bx; p.ty = by; p.tz = bz;
            p.sx = near(bx); p.sy = near(by); p.sz = near(bz);
            case ($urandom_range(0, 5))
                0:       p.mass = $urandom;
                1:       p.mass = '0;
                default: p.mass = $urandom_range(0, 1 << 20);
            endcase
            if ($urandom_range(0, 1))
            begin
                p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
            end
            else
            begin
                p.ax = $urandom_range(0, 1 << 18) - (1 << 17);
                p.ay = $urandom_range(0, 1 << 18) - (1 << 17);
                p.az = $urandom_range(0, 1 << 18) - (1 << 17);
            end
            p.first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
            p.last  = (i == len - 1) ? ($urandom_range(0, 9) != 0)
                                     : ($urandom_range(0, 19) == 0);
            pending_pairs.push_back(p);
        end
    endfunction

    task automatic write_softening(logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        eps2_model = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || push || expected_totals.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] eps_set[6];
        eps_set = '{32'd0, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'd0};
        eps_set[3] = $urandom;
        eps_set[5] = $urandom_range(0, 1 << 12);
        errors = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle = 26;
        recv_idle = 63;
        eps2_model = gpa_pkg::SOFTENING_RESET;
        run_x = '0; run_y = '0; run_z = '0;
        run_clipped = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 26 : (ph < 4) ? 63 : 0;
            recv_idle = (ph < 2) ? 63 : (ph < 4) ? 26 : 0;
            write_softening(eps_set[ph]);
            if (ph == 0)
            begin
                pending_pairs.push_back(mk(32'sd0, 32'sd0, 32'hFFFF_FFFF, 32'sd5, 1, 1));
                pending_pairs.push_back(mk(32'sd100, 32'sd100, 32'd1 << 16,
                                           32'sh7FFF_FFFF, 1, 1));
                pending_pairs.push_back(mk(32'sd0, 32'sd1, 32'hFFFF_FFFF,
                                           32'sh7FFF_FFF0, 1, 0));
                pending_pairs.push_back(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
                                           32'sd0, 0, 1));
                pending_pairs.push_back(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF,
                                           32'sh8000_0000, 1, 1));
                pending_pairs.push_back(mk(32'sd3, 32'sd1 << 16, 32'd0, 32'sd0, 0, 1));
                pending_pairs.push_back(mk(32'sd0, -32'sd2, 32'hFFFF_FFFF,
                                           -32'sh7FFF_FFF0, 1, 1));
                pending_pairs.push_back(mk(32'sd1 << 16, 32'sd2 << 16, 32'd1 << 16,
                                           32'sd0, 1, 0));
                pending_pairs.push_back(mk(32'sd0, -32'sd1 << 16, 32'd3 << 16,
                                           32'sd0, 0, 0));
                pending_pairs.push_back(mk(32'sd7, 32'sd7, 32'd9, 32'sd0, 0, 1));
                pending_pairs.push_back(mk(32'sh5555_5555, 32'shAAAA_AAAA, 32'h5555_5555,
                                           32'sh5555_5555, 0, 1));
                pending_pairs.push_back(mk(32'shAAAA_AAAA, 32'sh5555_5555, 32'hAAAA_AAAA,
                                           32'shAAAA_AAAA, 1, 1));
                pending_pairs.push_back(mk(32'sh1234_5678, 32'sh1234_5679, 32'd1,
                                           32'sd0, 1, 1));
            end
            else
            begin
                while (pending_pairs.size() < 340)
                    queue_run();
            end
            pending_pairs.push_back(mk($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1));
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #15ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
